// ===== src/bf3_pkg.sv =====
`default_nettype none

package bf3_pkg;

	localparam int COLS_MAX_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int VALUE_BITS      = 16;
	localparam int COLS_BITS       = 11;
	localparam int ROWS_BITS       = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_ADDR_BITS   = 1;

	localparam logic [COLS_BITS-1:0] COLS_RESET = 11'd1024;
	localparam logic [ROWS_BITS-1:0] ROWS_RESET = 16'd1024;

	// smallest frame edge the window logic supports
	localparam int MIN_EDGE = 3;

	// mean over the 3x3 window, rounded to nearest
	localparam int DIV_CONST = 9;
	localparam int ROUND_ADD = DIV_CONST / 2;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_FRAME_COLS = 1'b0,
		REG_FRAME_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_DRAIN  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic act_samp;
		logic emit;
		logic bypass;
		logic last;
		logic from_mem;
	} ctl_t;

endpackage

`default_nettype wire

// ===== src/box_filter_3x3_top.sv =====
// 3x3 box filter over a raster-ordered frame of unsigned samples.
// cfg port: cfg_we with cfg_addr 0 writes frame_cols, 1 writes frame_rows; any
// write restarts the frame. Sizes are clamped to 3..COLS_MAX columns, 3+ rows.
// s_* channel: one item per handshake, s_tuser 0 = sample, 1 = drain. Samples
// beyond the frame and drains before its end are dropped with no result.
// m_* channel: pixels in raster order, interior pixels as the rounded 3x3 mean,
// border rows and columns unchanged; m_tlast marks the final pixel. After the
// last sample, cols+1 drain items flush the remaining pixels.
// Throughput: one item per clock, sustained while the receiver does not stall.
// A pixel leaves one row plus one pixel after its own sample; the pipeline
// adds 4 register stages: line store read, window cells, the divide-by-9
// reciprocal multiply and the output register.
// Reset clears the positions, the window and the pipeline valids and sets both
// sizes to 1024; line store contents are undefined until written.
// When the receiver stalls, the whole pipeline and s_tready hold; an item is
// still taken while a result waits if the output register frees that cycle.
`default_nettype none

module box_filter_3x3_top #(
	parameter int COLS_MAX    = bf3_pkg::COLS_MAX_DEF,
	parameter int SAMPLE_BITS = bf3_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bf3_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  wire logic [bf3_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// sample
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	// opcode
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// value
	output logic      [bf3_pkg::VALUE_BITS-1:0]      m_tdata,
	output logic                                     m_tlast
);

	localparam int W    = SAMPLE_BITS;
	localparam int AW   = $clog2(COLS_MAX);
	localparam int CW   = $clog2(COLS_MAX + 1);
	localparam int CMPW = (CW > bf3_pkg::COLS_BITS) ? CW : bf3_pkg::COLS_BITS;
	localparam int RW   = bf3_pkg::ROWS_BITS;
	localparam int SUMW = W + 2;
	localparam int NUMW = W + 4;
	localparam int SIDW = W + 2;
	localparam int VW   = bf3_pkg::VALUE_BITS;

	logic [bf3_pkg::COLS_BITS-1:0] frame_cols_q;
	logic [RW-1:0]                 frame_rows_q;
	logic [AW-1:0]                 col_q;
	logic [RW-1:0]                 row_q;
	logic [CW-1:0]                 drain_q;

	logic [CMPW-1:0] cols_ext;
	logic [CW-1:0]   cols_eff;
	logic [RW-1:0]   rows_eff;

	logic          en;
	logic          accept;
	logic          is_drain;
	logic [W-1:0]  sample;
	logic          samp_act;
	logic          drain_act;
	logic          col_zero;
	logic          col_one;
	logic          col_last;
	logic          fin;
	logic          restart;
	logic [AW-1:0] rd_addr;
	bf3_pkg::ctl_t ctl_d;

	bf3_pkg::ctl_t ctl_s1;
	logic [AW-1:0] col_s1;
	logic [W-1:0]  sample_s1;

	logic [2*W-1:0] rd_data;
	logic [W-1:0]   rd_up;
	logic [W-1:0]   rd_mid;
	logic           shift;

	logic [W-1:0]    c2_top, c2_mid, c2_bot;
	logic [W-1:0]    c1_top, c1_mid, c1_bot;
	logic [SUMW-1:0] cs0, cs1, cs2;

	logic          vld_s2;
	logic          bypass_s2;
	logic          last_s2;
	logic [W-1:0]  bval_s2;
	logic [NUMW-1:0] dividend;

	logic            div_valid;
	logic [NUMW-1:0] div_quo;
	logic [SIDW-1:0] div_side;
	logic [W-1:0]    res;
	logic [VW+W-1:0] res_wide;

	logic          out_valid_q;
	logic [VW-1:0] out_value_q;
	logic          out_last_q;

	// effective frame size
	always_comb begin
		cols_ext = CMPW'(frame_cols_q);
		if (cols_ext < CMPW'(bf3_pkg::MIN_EDGE)) begin
			cols_ext = CMPW'(bf3_pkg::MIN_EDGE);
		end else if (cols_ext > CMPW'(COLS_MAX)) begin
			cols_ext = CMPW'(COLS_MAX);
		end
		cols_eff = CW'(cols_ext);
		rows_eff = (frame_rows_q < RW'(bf3_pkg::MIN_EDGE)) ? RW'(bf3_pkg::MIN_EDGE)
		                                                   : frame_rows_q;
	end

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign is_drain = (s_tuser == bf3_pkg::OP_DRAIN);
	assign sample   = s_tdata[W-1:0];

	always_comb begin
		samp_act  = !is_drain && (row_q < rows_eff);
		drain_act = is_drain && (row_q >= rows_eff);
		col_zero  = (col_q == '0);
		col_one   = (col_q == AW'(1));
		col_last  = (CW'(col_q) + CW'(1)) >= cols_eff;
		fin       = (drain_q == cols_eff);
		rd_addr   = is_drain ? AW'(drain_q - CW'(1)) : col_q;

		ctl_d = '0;
		if (accept && samp_act) begin
			ctl_d.act_samp = 1'b1;
			ctl_d.emit     = (col_zero && (row_q >= RW'(2))) || (!col_zero && (row_q != '0));
			ctl_d.bypass   = col_zero || col_one || (row_q == RW'(1));
		end else if (accept && drain_act) begin
			ctl_d.emit     = 1'b1;
			ctl_d.bypass   = 1'b1;
			ctl_d.last     = fin;
			ctl_d.from_mem = (drain_q != '0);
		end
		restart = cfg_we || (accept && drain_act && fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= bf3_pkg::COLS_RESET;
			frame_rows_q <= bf3_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			unique case (bf3_pkg::reg_idx_t'(cfg_addr))
				bf3_pkg::REG_FRAME_COLS: begin
					frame_cols_q <= cfg_wdata[bf3_pkg::COLS_BITS-1:0];
				end
				bf3_pkg::REG_FRAME_ROWS: begin
					frame_rows_q <= cfg_wdata[RW-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (accept && samp_act) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end else if (accept && drain_act) begin
			drain_q <= drain_q + CW'(1);
		end
	end

	// stage 1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1    <= col_q;
			sample_s1 <= sample;
		end
	end

	// each entry holds {middle line, upper line} of one column
	bf3_line_store #(
		.DEPTH (COLS_MAX),
		.AW    (AW),
		.DW    (2 * W)
	) u_lines (
		.clk     (clk),
		.rd_en   (en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (shift),
		.wr_addr (col_s1),
		.wr_data ({sample_s1, rd_mid})
	);

	assign rd_up  = rd_data[W-1:0];
	assign rd_mid = rd_data[2*W-1:W];
	assign shift  = en && ctl_s1.act_samp;

	bf3_cell #(.W(W)) u_cell2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.in_top  (rd_up),
		.in_mid  (rd_mid),
		.in_bot  (sample_s1),
		.out_top (c2_top),
		.out_mid (c2_mid),
		.out_bot (c2_bot),
		.out_sum (cs2)
	);

	bf3_cell #(.W(W)) u_cell1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.in_top  (c2_top),
		.in_mid  (c2_mid),
		.in_bot  (c2_bot),
		.out_top (c1_top),
		.out_mid (c1_mid),
		.out_bot (c1_bot),
		.out_sum (cs1)
	);

	bf3_cell #(.W(W)) u_cell0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.in_top  (c1_top),
		.in_mid  (c1_mid),
		.in_bot  (c1_bot),
		.out_top (),
		.out_mid (),
		.out_bot (),
		.out_sum (cs0)
	);

	// stage 2: window holds this item's neighborhood; border value is the
	// center before the shift, drain value comes from the middle line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= ctl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bypass_s2 <= ctl_s1.bypass;
			last_s2   <= ctl_s1.last;
			bval_s2   <= ctl_s1.from_mem ? rd_mid : c2_mid;
		end
	end

	assign dividend = NUMW'(cs0) + NUMW'(cs1) + NUMW'(cs2) + NUMW'(bf3_pkg::ROUND_ADD);

	bf3_div9 #(
		.NUM_BITS  (NUMW),
		.SIDE_BITS (SIDW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s2),
		.in_num    (dividend),
		.in_side   ({last_s2, bypass_s2, bval_s2}),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	assign res      = div_side[W] ? div_side[W-1:0] : div_quo[W-1:0];
	assign res_wide = {{VW{1'b0}}, res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_value_q <= res_wide[VW-1:0];
			out_last_q  <= div_side[W+1];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(col_q) < cols_eff)
		else $error("column position beyond row length");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= rows_eff)
		else $error("row position beyond frame");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q <= cols_eff)
		else $error("drain count beyond row length");

	a_drain_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q != '0) |-> (row_q >= rows_eff))
		else $error("drain count set while frame open");

	a_final_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && drain_act && fin) |=> (row_q == '0 && col_q == '0 && drain_q == '0))
		else $error("final drain item did not restart the frame");
`endif

endmodule

`default_nettype wire

// ===== src/bf3_line_store.sv =====
`default_nettype none

module bf3_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== src/bf3_cell.sv =====
`default_nettype none

module bf3_cell #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift,
	input  wire logic [W-1:0] in_top,
	input  wire logic [W-1:0] in_mid,
	input  wire logic [W-1:0] in_bot,
	output logic      [W-1:0] out_top,
	output logic      [W-1:0] out_mid,
	output logic      [W-1:0] out_bot,
	output logic      [W+1:0] out_sum
);

	logic [W-1:0] top_q;
	logic [W-1:0] mid_q;
	logic [W-1:0] bot_q;
	logic [W+1:0] sum_q;

	// one window column; its sum travels with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			mid_q <= '0;
			bot_q <= '0;
			sum_q <= '0;
		end else if (shift) begin
			top_q <= in_top;
			mid_q <= in_mid;
			bot_q <= in_bot;
			sum_q <= (W+2)'(in_top) + (W+2)'(in_mid) + (W+2)'(in_bot);
		end
	end

	assign out_top = top_q;
	assign out_mid = mid_q;
	assign out_bot = bot_q;
	assign out_sum = sum_q;

endmodule

`default_nettype wire

// ===== src/bf3_div9.sv =====
`default_nettype none

module bf3_div9 #(
	parameter int NUM_BITS  = 20,
	parameter int SIDE_BITS = 18
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [NUM_BITS-1:0]  in_num,
	input  wire logic [SIDE_BITS-1:0] in_side,
	output logic                      out_valid,
	output logic      [NUM_BITS-1:0]  out_quo,
	output logic      [SIDE_BITS-1:0] out_side
);

	localparam int SHIFT = NUM_BITS + 3;
	localparam int PW    = 2 * NUM_BITS;
	// ceil(2^SHIFT / 9); with the shift three bits past the dividend width the
	// high part of the product is the exact quotient for every dividend
	localparam logic [NUM_BITS-1:0] RECIP = NUM_BITS'(((64'd1 << SHIFT)
		+ 64'(bf3_pkg::DIV_CONST - 1)) / 64'(bf3_pkg::DIV_CONST));

	logic                 vld_q;
	logic [PW-1:0]        prod_q;
	logic [SIDE_BITS-1:0] side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_valid;
		end
	end

	// reciprocal multiply by the constant
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(in_num) * PW'(RECIP);
			side_q <= in_side;
		end
	end

	assign out_valid = vld_q;
	assign out_quo   = NUM_BITS'(prod_q[PW-1:SHIFT]);
	assign out_side  = side_q;

endmodule

`default_nettype wire

// ===== verif/box_filter_3x3_checker.sv =====
module box_filter_3x3_checker
	import bf3_pkg::*;
#(
	parameter int COLS_MAX = COLS_MAX_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  reg_idx_t                 cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [15:0]              s_tdata,
	input  logic                     s_tuser,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [VALUE_BITS-1:0]    m_tdata,
	input  logic                     m_tlast,
	output int                       pending,
	output int                       fail_count
);

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		logic                  last;
	} pixel_t;

	pixel_t pixel_q[$];

	logic [15:0] upper_mem [COLS_MAX];
	logic [15:0] middle_mem [COLS_MAX];
	logic [15:0] win [9];
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned drain_cnt;
	logic [COLS_BITS-1:0] cols_reg;
	logic [ROWS_BITS-1:0] rows_reg;

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin : predict
		int unsigned x;
		int unsigned y;
		int unsigned w;
		int unsigned h;
		int unsigned d;
		int unsigned sum;
		logic [15:0] right_px;
		pixel_t want;
		if (!arst_n) begin
			pixel_q.delete();
			for (int i = 0; i < COLS_MAX; i++) begin
				upper_mem[i] = '0;
				middle_mem[i] = '0;
			end
			for (int i = 0; i < 9; i++) win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			drain_cnt = 0;
			cols_reg = COLS_RESET;
			rows_reg = ROWS_RESET;
			pending = 0;
		end else begin
			// an output never stems from an item taken on the same edge, so match first
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					$error("unexpected item: value %0d last %0b", m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = pixel_q.pop_front();
					if (m_tdata !== want.value) begin
						$error("value: expected %0d, actual %0d", want.value, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, m_tlast);
						fail_count++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_addr)
					REG_FRAME_COLS: cols_reg = cfg_wdata[COLS_BITS-1:0];
					REG_FRAME_ROWS: rows_reg = cfg_wdata[ROWS_BITS-1:0];
				endcase
				col_pos = 0;
				row_pos = 0;
				drain_cnt = 0;
			end

			if (s_tvalid && s_tready) begin
				w = (cols_reg < MIN_EDGE) ? MIN_EDGE :
					(cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
				h = (rows_reg < MIN_EDGE) ? MIN_EDGE : rows_reg;
				if (s_tuser == OP_SAMPLE) begin
					if (row_pos < h) begin
						x = (col_pos >= w) ? 0 : col_pos;
						y = row_pos;
						right_px = win[5];
						for (int r = 0; r < 3; r++) begin
							win[r*3]   = win[r*3+1];
							win[r*3+1] = win[r*3+2];
						end
						win[2] = upper_mem[x];
						win[5] = middle_mem[x];
						win[8] = s_tdata;
						upper_mem[x] = middle_mem[x];
						middle_mem[x] = s_tdata;

						// column 0 releases the right border pixel two rows up
						if (x == 0 && y >= 2) begin
							pixel_q.push_back('{right_px, 1'b0});
						end else if (x >= 1 && y >= 1) begin
							if (y == 1 || x == 1) begin
								pixel_q.push_back('{win[4], 1'b0});
							end else begin
								sum = 0;
								for (int k = 0; k < 9; k++) sum += win[k];
								pixel_q.push_back('{16'((sum + ROUND_ADD) / DIV_CONST), 1'b0});
							end
						end

						if (x + 1 >= w) begin
							col_pos = 0;
							row_pos = y + 1;
						end else begin
							col_pos = x + 1;
						end
					end
				end else if (row_pos >= h) begin
					d = (drain_cnt > w) ? w : drain_cnt;
					right_px = (d == 0) ? win[5] : middle_mem[d-1];
					pixel_q.push_back('{right_px, (d == w)});
					if (d == w) begin
						col_pos = 0;
						row_pos = 0;
						drain_cnt = 0;
					end else begin
						drain_cnt = d + 1;
					end
				end
			end
			pending = pixel_q.size();
		end
	end

endmodule

// ===== verif/tb_box_filter_3x3_top.sv =====
module tb_box_filter_3x3_top;
	import bf3_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	reg_idx_t                 cfg_addr = REG_FRAME_COLS;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	// sample
	logic [15:0]              s_tdata = '0;
	// opcode
	logic                     s_tuser = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	// value
	logic [VALUE_BITS-1:0]    m_tdata;
	logic                     m_tlast;

	int pending;
	int fail_count;
	int rx_count = 0;
	int items_sent = 0;
	int unsigned frame_w = COLS_RESET;
	int unsigned frame_h = ROWS_RESET;
	bit steady_tx = 1'b0;
	bit steady_rx = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	box_filter_3x3_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	box_filter_3x3_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.pending    (pending),
		.fail_count (fail_count)
	);

	task automatic send_item(input opcode_t op, input logic [15:0] px);
		int gap;
		if ($urandom_range(0, 49) == 0) steady_tx = ~steady_tx;
		gap = steady_tx ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= px;
		do @(posedge clk); while (!(s_tvalid && s_tready));
	endtask

	// only while idle; leaves time for dropped items still in the pipeline
	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_COLS)
			frame_w = (val[10:0] < MIN_EDGE) ? MIN_EDGE :
				(val[10:0] > COLS_MAX_DEF) ? COLS_MAX_DEF : val[10:0];
		else
			frame_h = (val < MIN_EDGE) ? MIN_EDGE : val;
	endtask

	// abort_at < 0 runs the whole frame and its drain
	task automatic send_frame(input int abort_at, input bit noise);
		int n;
		int i;
		logic [15:0] px;
		n = frame_w * frame_h;
		for (i = 0; i < n; i++) begin
			if (i == abort_at) return;
			if (noise && $urandom_range(0, 29) == 0) send_item(OP_DRAIN, 16'($urandom));
			case ($urandom_range(0, 7))
				0: px = '0;
				1: px = 16'hFFFF;
				default: px = 16'($urandom);
			endcase
			send_item(OP_SAMPLE, px);
			items_sent++;
		end
		// sample past the frame end is dropped
		if (noise && $urandom_range(0, 3) == 0) send_item(OP_SAMPLE, 16'($urandom));
		for (i = 0; i <= frame_w; i++) begin
			send_item(OP_DRAIN, 16'($urandom));
			items_sent++;
		end
		// drain after the frame restarted is dropped
		if (noise && $urandom_range(0, 3) == 0) send_item(OP_DRAIN, 16'($urandom));
	endtask

	// receiver: random stalls, plus long hold-offs that back the block up
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 49) == 0) steady_rx = ~steady_rx;
			gap = steady_rx ? 0 : $urandom_range(0, 10);
			if (rx_count == 150 || rx_count == 300) gap = 400;
			repeat (gap) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			rx_count++;
		end
	end

	initial begin : stimulus
		int i;
		int abort_at;
		bit need_cfg;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// smallest frame, all samples at full scale, with dropped items around it
		write_reg(REG_FRAME_COLS, 16'h0002);
		write_reg(REG_FRAME_ROWS, 16'h0000);
		send_item(OP_DRAIN, 16'hFFFF);
		repeat (9) send_item(OP_SAMPLE, 16'hFFFF);
		send_item(OP_SAMPLE, 16'h0000);
		repeat (4) send_item(OP_DRAIN, 16'h0000);
		send_item(OP_DRAIN, 16'hFFFF);

		// masked column bits, full-scale samples alternating with small ones
		write_reg(REG_FRAME_COLS, 16'hF801);
		write_reg(REG_FRAME_ROWS, 16'h0002);
		for (i = 0; i < 9; i++) send_item(OP_SAMPLE, (i % 2) ? 16'hFFFF : 16'(i));
		repeat (4) send_item(OP_DRAIN, 16'h0000);

		// oversized columns clamp to the widest line; cut short in the first row
		write_reg(REG_FRAME_COLS, 16'hFFFF);
		write_reg(REG_FRAME_ROWS, 16'hFFFF);
		send_frame(120, 1'b0);
		need_cfg = 1'b1;

		while (items_sent < 550) begin
			if (need_cfg || $urandom_range(0, 2) == 0) begin
				if (need_cfg || $urandom_range(0, 1) == 0)
					write_reg(REG_FRAME_COLS, {5'($urandom),
						($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2)) :
						11'($urandom_range(3, 10))});
				if ($urandom_range(0, 1) == 0)
					write_reg(REG_FRAME_ROWS, ($urandom_range(0, 9) == 0) ?
						16'($urandom_range(0, 2)) : 16'($urandom_range(3, 6)));
			end
			abort_at = ($urandom_range(0, 7) == 0) ?
				$urandom_range(0, frame_w * frame_h - 1) : -1;
			send_frame(abort_at, 1'b1);
			need_cfg = (abort_at >= 0);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#(20 * 1_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule
